// ===== hw/rtl/abkf_pkg.sv =====
// Shared types, constants and fixed-point helpers for the angle/bias Kalman filter.
package abkf_pkg;

  localparam int unsigned FracBits = 30;
  localparam int unsigned CfgW     = 31;
  localparam int unsigned IdxW     = 2;

  localparam logic [IdxW-1:0] RegDt     = 2'd0;
  localparam logic [IdxW-1:0] RegQAngle = 2'd1;
  localparam logic [IdxW-1:0] RegQBias  = 2'd2;
  localparam logic [IdxW-1:0] RegR      = 2'd3;

  localparam logic [CfgW-1:0] DtReset     = 31'd5368709;
  localparam logic [CfgW-1:0] QAngleReset = 31'd751619;
  localparam logic [CfgW-1:0] QBiasReset  = 31'd5368709;
  localparam logic [CfgW-1:0] RReset      = 31'd536870912;
  localparam logic signed [31:0] OneQ30   = 32'sd1073741824;

  // Multiplier operand selects.
  localparam logic [3:0] MulAPred = 4'd0;
  localparam logic [3:0] MulQ00   = 4'd1;
  localparam logic [3:0] MulQ01   = 4'd2;
  localparam logic [3:0] MulAng   = 4'd3;
  localparam logic [3:0] MulBias  = 4'd4;
  localparam logic [3:0] MulP00   = 4'd5;
  localparam logic [3:0] MulP01   = 4'd6;
  localparam logic [3:0] MulP10   = 4'd7;
  localparam logic [3:0] MulP11   = 4'd8;

  typedef struct packed {
    logic       load;      // capture inputs, prepare q11, inner, g-b
    logic       mul_go;    // issue multiply and write its result
    logic [3:0] mul_sel;
    logic       div_start; // start both gain divisions
    logic       div_step;
    logic       out_load;
  } abkf_cmd_t;

  typedef struct packed {
    logic div_done;
  } abkf_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // Rounded arithmetic shift by 30, ties toward plus infinity.
  function automatic logic signed [35:0] rnd30(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = p + 66'sd536870912;
    return 36'(t >>> FracBits);
  endfunction

endpackage

// ===== hw/rtl/abkf_ctrl.sv =====
// Sequencer for the filter: multiply schedule, division and result handshake.
module abkf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  abkf_pkg::abkf_sts_t sts_i,
  output abkf_pkg::abkf_cmd_t cmd_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul1 = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StMul2 = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       ov_q, ov_d;

  assign in_ready  = (state_q == StIdle);
  assign out_valid = ov_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    ov_d    = ov_q;
    cmd_o   = '0;
    if (ov_q && out_ready) ov_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_d    = StMul1;
          step_d     = abkf_pkg::MulAPred;
        end
      end
      StMul1: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = step_q;
        if (step_q == abkf_pkg::MulQ01) begin
          state_d = StDiv;
          cmd_o.div_start = 1'b0;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      StDiv: begin
        if (step_q == abkf_pkg::MulQ01) begin
          cmd_o.div_start = 1'b1;
          step_d = abkf_pkg::MulAng;
        end else if (sts_i.div_done) begin
          state_d = StMul2;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StMul2: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = step_q;
        if (step_q == abkf_pkg::MulP11) state_d = StOut;
        else step_d = step_q + 4'd1;
      end
      StOut: begin
        if (!ov_q || out_ready) begin
          cmd_o.out_load = 1'b1;
          ov_d    = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ov_q    <= ov_d;
    end
  end
endmodule

// ===== hw/rtl/abkf_div.sv =====
// Restoring divider producing both Kalman gains, one quotient bit per cycle while step_i is high.
module abkf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               step_i,
  input  logic signed [31:0] num0_i,
  input  logic signed [31:0] num1_i,
  input  logic signed [32:0] den_i,
  output logic               done_o,
  output logic signed [31:0] k0_o,
  output logic signed [31:0] k1_o
);
  // |num*2^30| <= 2^61, quotient up to 62 bits.
  logic [61:0] n0_q, n1_q, q0_q, q1_q;
  logic [62:0] r0_q, r1_q;
  logic [32:0] d_q;
  logic        s0_q, s1_q, z_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [62:0] r0_t, r1_t;
  logic [31:0] an0, an1;

  assign an0 = num0_i[31] ? 32'(-num0_i) : 32'(num0_i);
  assign an1 = num1_i[31] ? 32'(-num1_i) : 32'(num1_i);
  assign r0_t = {r0_q[61:0], n0_q[61]};
  assign r1_t = {r1_q[61:0], n1_q[61]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd62;
    end else if (step_i && busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n0_q <= {an0, 30'd0};
      n1_q <= {an1, 30'd0};
      d_q  <= den_i[32] ? 33'(-den_i) : 33'(den_i);
      s0_q <= num0_i[31] ^ den_i[32];
      s1_q <= num1_i[31] ^ den_i[32];
      z_q  <= (den_i == '0);
      r0_q <= '0;
      r1_q <= '0;
      q0_q <= '0;
      q1_q <= '0;
    end else if (step_i && busy_q) begin
      n0_q <= {n0_q[60:0], 1'b0};
      n1_q <= {n1_q[60:0], 1'b0};
      if (r0_t >= {30'd0, d_q}) begin
        r0_q <= r0_t - {30'd0, d_q};
        q0_q <= {q0_q[60:0], 1'b1};
      end else begin
        r0_q <= r0_t;
        q0_q <= {q0_q[60:0], 1'b0};
      end
      if (r1_t >= {30'd0, d_q}) begin
        r1_q <= r1_t - {30'd0, d_q};
        q1_q <= {q1_q[60:0], 1'b1};
      end else begin
        r1_q <= r1_t;
        q1_q <= {q1_q[60:0], 1'b0};
      end
    end
  end

  assign done_o = !busy_q && !start_i;

  always_comb begin
    logic signed [65:0] v0, v1;
    v0 = s0_q ? -$signed({4'd0, q0_q}) : $signed({4'd0, q0_q});
    v1 = s1_q ? -$signed({4'd0, q1_q}) : $signed({4'd0, q1_q});
    k0_o = z_q ? '0 : abkf_pkg::sat32(v0);
    k1_o = z_q ? '0 : abkf_pkg::sat32(v1);
  end
endmodule

// ===== hw/rtl/abkf_dp.sv =====
// Datapath: configuration, state, shared multiplier and update arithmetic.
module abkf_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [30:0]         cfg_data_i,
  input  logic signed [31:0]  accel_angle_i,
  input  logic signed [31:0]  gyro_rate_i,
  input  abkf_pkg::abkf_cmd_t cmd_i,
  output abkf_pkg::abkf_sts_t sts_o,
  output logic signed [31:0]  fused_angle_o,
  output logic signed [31:0]  bias_estimate_o,
  output logic signed [31:0]  corrected_rate_o
);
  logic [30:0] dt_q, qa_q, qb_q, r_q;
  logic signed [31:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [31:0] acc_q, gyr_q, inner_q, q00_q, q01_q, q10_q, q11_q, apred_q;
  logic signed [32:0] gdiff_q;
  logic signed [31:0] k0, k1;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [35:0] pr;
  logic signed [33:0] err;
  logic signed [32:0] s_den;
  logic               ddone;

  assign s_den = 33'(q00_q) + $signed({2'b0, r_q});

  abkf_div u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start), .step_i(cmd_i.div_step),
    .num0_i(q00_q), .num1_i(q10_q), .den_i(s_den),
    .done_o(ddone), .k0_o(k0), .k1_o(k1)
  );
  assign sts_o.div_done = ddone;

  assign err = 34'(acc_q) - 34'(apred_q);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd_i.mul_sel)
      abkf_pkg::MulAPred: begin ma = $signed({2'b0, dt_q}); mb = gdiff_q; end
      abkf_pkg::MulQ00:   begin ma = $signed({2'b0, dt_q}); mb = 33'(inner_q); end
      abkf_pkg::MulQ01:   begin ma = 33'(p11_q); mb = $signed({2'b0, dt_q}); end
      abkf_pkg::MulAng:   begin ma = 33'(k0); mb = 33'(err); end
      abkf_pkg::MulBias:  begin ma = 33'(k1); mb = 33'(err); end
      abkf_pkg::MulP00:   begin ma = 33'(q00_q); mb = 33'(k0); end
      abkf_pkg::MulP01:   begin ma = 33'(q01_q); mb = 33'(k0); end
      abkf_pkg::MulP10:   begin ma = 33'(q00_q); mb = 33'(k1); end
      abkf_pkg::MulP11:   begin ma = 33'(q01_q); mb = 33'(k1); end
      default: ;
    endcase
  end

  // err can reach 33 bits; handled via 34-bit operand path for the two error products.
  logic signed [33:0] mb_w;
  always_comb begin
    mb_w = 34'(mb);
    if (cmd_i.mul_sel == abkf_pkg::MulAng || cmd_i.mul_sel == abkf_pkg::MulBias) mb_w = err;
  end
  assign prod = 66'(ma) * 66'(mb_w);
  assign pr   = abkf_pkg::rnd30(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= abkf_pkg::DtReset;
      qa_q <= abkf_pkg::QAngleReset;
      qb_q <= abkf_pkg::QBiasReset;
      r_q  <= abkf_pkg::RReset;
      ang_q  <= '0;
      bias_q <= '0;
      p00_q  <= abkf_pkg::OneQ30;
      p01_q  <= '0;
      p10_q  <= '0;
      p11_q  <= abkf_pkg::OneQ30;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          abkf_pkg::RegDt:     dt_q <= cfg_data_i;
          abkf_pkg::RegQAngle: qa_q <= cfg_data_i;
          abkf_pkg::RegQBias:  qb_q <= cfg_data_i;
          abkf_pkg::RegR:      r_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.mul_go) begin
        unique case (cmd_i.mul_sel)
          abkf_pkg::MulAng:  ang_q  <= abkf_pkg::sat32(66'(apred_q) + 66'(pr));
          abkf_pkg::MulBias: bias_q <= abkf_pkg::sat32(66'(bias_q) + 66'(pr));
          abkf_pkg::MulP00:  p00_q  <= abkf_pkg::sat32(66'(q00_q) - 66'(pr));
          abkf_pkg::MulP01:  p01_q  <= abkf_pkg::sat32(66'(q01_q) - 66'(pr));
          abkf_pkg::MulP10:  p10_q  <= abkf_pkg::sat32(66'(q10_q) - 66'(pr));
          abkf_pkg::MulP11:  p11_q  <= abkf_pkg::sat32(66'(q11_q) - 66'(pr));
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_q   <= accel_angle_i;
      gyr_q   <= gyro_rate_i;
      gdiff_q <= 33'(gyro_rate_i) - 33'(bias_q);
      inner_q <= abkf_pkg::sat32(66'($signed({1'b0, qa_q})) - 66'(p10_q) - 66'(p01_q));
      q11_q   <= abkf_pkg::sat32(66'(p11_q) + 66'($signed({1'b0, qb_q})));
    end
    if (cmd_i.mul_go) begin
      unique case (cmd_i.mul_sel)
        abkf_pkg::MulAPred: apred_q <= abkf_pkg::sat32(66'(ang_q) + 66'(pr));
        abkf_pkg::MulQ00:   q00_q   <= abkf_pkg::sat32(66'(p00_q) + 66'(pr));
        abkf_pkg::MulQ01: begin
          q01_q <= abkf_pkg::sat32(66'(p01_q) - 66'(pr));
          q10_q <= abkf_pkg::sat32(66'(p10_q) - 66'(pr));
        end
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      fused_angle_o    <= ang_q;
      bias_estimate_o  <= bias_q;
      corrected_rate_o <= abkf_pkg::sat32(66'(gyr_q) - 66'(bias_q));
    end
  end
endmodule

// ===== hw/rtl/angle_bias_kalman_filter.sv =====
// Top level of the two-state angle/gyro-bias Kalman filter.
// One item at a time: a sample is accepted only in the idle state, and the
// sequencer returns to idle once the result is loaded. The time goes to
// three prediction multiplies, a division step that forms both gains
// together (start, 62 quotient bits one per cycle, finish), six update
// multiplies on one shared multiplier and an output step that waits while
// an older result is unread. The result register lets a finished result
// wait while the next item is taken. Configuration writes take effect at once.
module angle_bias_kalman_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] accel_angle_i,
  input  logic signed [31:0] gyro_rate_i,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] fused_angle_o,
  output logic signed [31:0] bias_estimate_o,
  output logic signed [31:0] corrected_rate_o
);
  abkf_pkg::abkf_cmd_t cmd;
  abkf_pkg::abkf_sts_t sts;

  abkf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts_i(sts), .cmd_o(cmd)
  );

  abkf_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .accel_angle_i, .gyro_rate_i, .cmd_i(cmd), .sts_o(sts),
    .fused_angle_o, .bias_estimate_o, .corrected_rate_o
  );
endmodule

// ===== hw/rtl/abkf_checker.sv =====
// Port-level checks for the Kalman filter top level.
module abkf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [31:0] fused_angle_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(fused_angle_o))
    else $error("result dropped or changed while stalled");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> ##1 !$rose(out_valid))
    else $error("result too early");
endmodule

bind angle_bias_kalman_filter abkf_checker u_abkf_checker (
  .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready, .fused_angle_o
);

// ===== tb/sv/angle_bias_kalman_filter_test.sv =====
// Self-checking testbench for the angle/gyro-bias Kalman filter.
module angle_bias_kalman_filter_test;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] bias;
    logic signed [31:0] rate;
  } fused_t;

  class fusion_scoreboard;
    logic [30:0] dt, q_angle, q_bias, r_noise;
    logic signed [31:0] ang, bia, p00, p01, p10, p11;
    fused_t pending[$];
    int errors;

    function new();
      dt = abkf_pkg::DtReset; q_angle = abkf_pkg::QAngleReset;
      q_bias = abkf_pkg::QBiasReset; r_noise = abkf_pkg::RReset;
      ang = 0; bia = 0; p00 = abkf_pkg::OneQ30; p01 = 0; p10 = 0; p11 = abkf_pkg::OneQ30;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [30:0] val);
      case (idx)
        abkf_pkg::RegDt: dt = val;
        abkf_pkg::RegQAngle: q_angle = val;
        abkf_pkg::RegQBias: q_bias = val;
        abkf_pkg::RegR: r_noise = val;
        default: ;
      endcase
    endfunction

    static function logic signed [31:0] clip(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    static function longint qmul(longint a, longint b);
      longint p;
      p = a * b + 64'sd536870912;
      return p >>> 30;
    endfunction

    static function logic signed [31:0] kgain(longint num, longint den);
      if (den == 0) return 0;
      return clip((num * 64'sd1073741824) / den);
    endfunction

    function void note_sample(logic signed [31:0] accel, logic signed [31:0] gyro);
      logic signed [31:0] ap, q00, q01, q10, q11, inner, k0, k1;
      longint s, e, dtl;
      fused_t f;
      dtl = longint'({1'b0, dt});
      ap = clip(longint'(ang) + qmul(dtl, longint'(gyro) - longint'(bia)));
      inner = clip(longint'({1'b0, q_angle}) - longint'(p10) - longint'(p01));
      q00 = clip(longint'(p00) + qmul(dtl, longint'(inner)));
      q01 = clip(longint'(p01) - qmul(longint'(p11), dtl));
      q10 = clip(longint'(p10) - qmul(longint'(p11), dtl));
      q11 = clip(longint'(p11) + longint'({1'b0, q_bias}));
      s = longint'(q00) + longint'({1'b0, r_noise});
      k0 = kgain(longint'(q00), s);
      k1 = kgain(longint'(q10), s);
      e = longint'(accel) - longint'(ap);
      ang = clip(longint'(ap) + qmul(longint'(k0), e));
      bia = clip(longint'(bia) + qmul(longint'(k1), e));
      p00 = clip(longint'(q00) - qmul(longint'(q00), longint'(k0)));
      p01 = clip(longint'(q01) - qmul(longint'(q01), longint'(k0)));
      p10 = clip(longint'(q10) - qmul(longint'(q00), longint'(k1)));
      p11 = clip(longint'(q11) - qmul(longint'(q01), longint'(k1)));
      f.angle = ang; f.bias = bia;
      f.rate = clip(longint'(gyro) - longint'(bia));
      pending.push_back(f);
    endfunction

    function void check_result(logic signed [31:0] a, logic signed [31:0] b,
                               logic signed [31:0] r);
      fused_t f;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h %h %h", $time, a, b, r);
        errors++;
        return;
      end
      f = pending.pop_front();
      if (a !== f.angle) begin
        $display("%0t: fused_angle exp %h got %h", $time, f.angle, a);
        errors++;
      end
      if (b !== f.bias) begin
        $display("%0t: bias_estimate exp %h got %h", $time, f.bias, b);
        errors++;
      end
      if (r !== f.rate) begin
        $display("%0t: corrected_rate exp %h got %h", $time, f.rate, r);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [1:0] cfg_idx_i = '0;
  logic [30:0] cfg_data_i = '0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] accel_angle_i = '0;
  logic signed [31:0] gyro_rate_i = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] fused_angle_o, bias_estimate_o, corrected_rate_o;
  fusion_scoreboard sb = new();
  bit hold_rx = 0;

  angle_bias_kalman_filter u_dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    sb.write_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic send_sample(logic signed [31:0] accel, logic signed [31:0] gyro, bit gaps);
    int g;
    g = gaps ? pick_gap() : 0;
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid <= 1; accel_angle_i <= accel; gyro_rate_i <= gyro;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sb.note_sample(accel, gyro);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(0, 180 << 17)) - (180 <<< 16);
    endcase
  endfunction

  function automatic logic [30:0] rand_cfg(logic [30:0] lo);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return 31'h7fffffff;
      2: return 31'($urandom_range(lo, 31'd53687091));
      default: return 31'($urandom() | lo);
    endcase
  endfunction

  // receiver: random stalls, one long hold-off early on
  always @(posedge clk_i) begin
    if (out_valid && out_ready) begin
      sb.check_result(fused_angle_o, bias_estimate_o, corrected_rate_o);
    end
  end

  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      if (hold_rx) begin
        out_ready <= 0;
        repeat (600) @(posedge clk_i);
        hold_rx = 0;
      end
      g = pick_gap();
      if (g != 0) begin
        out_ready <= 0;
        repeat (g) @(posedge clk_i);
      end
      out_ready <= 1;
      @(posedge clk_i);
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_sample(0, 0, 0);
    send_sample(32'sh7fffffff, 32'sh80000000, 0);
    send_sample(32'sh80000000, 32'sh7fffffff, 0);
    send_sample(32'sh00010000, 32'sh00020000, 0);
    send_sample(-32'sh00010000, 32'shffffffff, 0);
    send_sample(32'sh55555555, 32'shaaaaaaaa, 0);
    send_sample(32'shaaaaaaaa, 32'sh55555555, 0);
    drain();
    write_reg(abkf_pkg::RegR, 31'd0);
    write_reg(abkf_pkg::RegQAngle, 31'd0);
    write_reg(abkf_pkg::RegQBias, 31'd0);
    write_reg(abkf_pkg::RegDt, 31'd0);
    send_sample(32'sh7fffffff, 32'sh7fffffff, 0);
    send_sample(32'sh80000000, 32'sh12345678, 0);
    drain();
    write_reg(abkf_pkg::RegR, 31'h7fffffff);
    write_reg(abkf_pkg::RegQAngle, 31'h7fffffff);
    write_reg(abkf_pkg::RegQBias, 31'h7fffffff);
    write_reg(abkf_pkg::RegDt, 31'h7fffffff);
    repeat (6) send_sample(rand_angle(), rand_angle(), 0);
    drain();
    write_reg(abkf_pkg::RegR, 31'd1);
    repeat (4) send_sample(rand_angle(), rand_angle(), 0);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        write_reg(abkf_pkg::RegDt, abkf_pkg::DtReset);
        write_reg(abkf_pkg::RegQAngle, abkf_pkg::QAngleReset);
        write_reg(abkf_pkg::RegQBias, abkf_pkg::QBiasReset);
        write_reg(abkf_pkg::RegR, abkf_pkg::RReset);
        hold_rx = 1;
      end else begin
        write_reg(abkf_pkg::RegDt, rand_cfg(0)); write_reg(abkf_pkg::RegQAngle, rand_cfg(0));
        write_reg(abkf_pkg::RegQBias, rand_cfg(0)); write_reg(abkf_pkg::RegR, rand_cfg(1));
      end
      repeat (100) send_sample(rand_angle(), rand_angle(), 1);
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/abkf_pkg.sv
hw/rtl/abkf_ctrl.sv
hw/rtl/abkf_div.sv
hw/rtl/abkf_dp.sv
hw/rtl/angle_bias_kalman_filter.sv
hw/rtl/abkf_checker.sv
tb/sv/angle_bias_kalman_filter_test.sv
